[hw/rtl/assert_macros.svh]
// Assertion helpers for the ring buffer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, held off while reset is asserted.
`define URTB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, but also checked during reset.
`define URTB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/urtb_pkg.sv]
`timescale 1ns / 1ps

package urtb_pkg;

	// event kinds
	localparam logic [2:0] KIND_LINE_BYTE = 3'd0;
	localparam logic [2:0] KIND_HOST_READ = 3'd1;
	localparam logic [2:0] KIND_HOST_WRITE = 3'd2;
	localparam logic [2:0] KIND_TX_DONE = 3'd3;
	localparam logic [2:0] KIND_FLUSH = 3'd4;

	// result status codes
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_RX_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_TX_FULL = 2'd2;

	typedef struct packed {
		logic rx_wr;
		logic rx_rd;
		logic tx_wr;
		logic tx_rd;
	} ram_ctl_t;

	typedef struct packed {
		logic [1:0] status;
		logic       send_valid;
		logic       use_rx_data;
		logic       use_tx_data;
		logic [7:0] direct_byte;
		logic       overflow;
	} res_info_t;

endpackage

[hw/rtl/urtb_chan_if.sv]
`timescale 1ns / 1ps

interface urtb_evt_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface urtb_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] read_byte;
	logic       send_valid;
	logic [7:0] send_byte;
	logic       overflow_seen;

	modport source (output valid, output status, output read_byte, output send_valid,
		output send_byte, output overflow_seen, input ready);
	modport sink (input valid, input status, input read_byte, input send_valid,
		input send_byte, input overflow_seen, output ready);
endinterface

[hw/rtl/urtb_ram.sv]
`timescale 1ns / 1ps

module urtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// read data holds until the next read
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/urtb_ctrl.sv]
`timescale 1ns / 1ps

module urtb_ctrl import urtb_pkg::*; #(
	parameter int RX_DEPTH = 16,
	parameter int TX_DEPTH = 16,
	localparam int RAW = $clog2(RX_DEPTH),
	localparam int TAW = $clog2(TX_DEPTH),
	localparam int TCW = $clog2(TX_DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [2:0]     kind,
	input  logic [7:0]     data_byte,
	output ram_ctl_t       ram_ctl,
	output logic [RAW-1:0] rx_wr_addr,
	output logic [RAW-1:0] rx_rd_addr,
	output logic [TAW-1:0] tx_wr_addr,
	output logic [TAW-1:0] tx_rd_addr,
	output res_info_t      info
);

	localparam logic [RAW-1:0] RX_LAST = RAW'(RX_DEPTH - 1);
	localparam logic [TAW-1:0] TX_LAST = TAW'(TX_DEPTH - 1);
	localparam logic [TCW-1:0] TX_FULL = TCW'(TX_DEPTH);

	logic [RAW-1:0] rx_wptr_q, rx_rptr_q, rx_cnt_q;
	logic [RAW-1:0] rx_wptr_d, rx_rptr_d, rx_cnt_d;
	logic [TAW-1:0] tx_wptr_q, tx_rptr_q, tx_wptr_d, tx_rptr_d;
	logic [TCW-1:0] tx_cnt_q, tx_cnt_d;
	logic           tx_busy_q, tx_busy_d;
	logic           ovf_q, ovf_d;

	assign rx_wr_addr = rx_wptr_q;
	assign rx_rd_addr = rx_rptr_q;
	assign tx_wr_addr = tx_wptr_q;
	assign tx_rd_addr = tx_rptr_q;

	always_comb begin
		rx_wptr_d = rx_wptr_q;
		rx_rptr_d = rx_rptr_q;
		rx_cnt_d  = rx_cnt_q;
		tx_wptr_d = tx_wptr_q;
		tx_rptr_d = tx_rptr_q;
		tx_cnt_d  = tx_cnt_q;
		tx_busy_d = tx_busy_q;
		ovf_d     = ovf_q;
		ram_ctl   = '0;
		info      = '0;
		info.status = STATUS_OK;
		if (go) begin
			unique case (kind)
				KIND_LINE_BYTE: begin
					ram_ctl.rx_wr = 1'b1;
					rx_wptr_d = (rx_wptr_q == RX_LAST) ? '0 : rx_wptr_q + 1'b1;
					// count wraps to zero on reaching depth
					if (rx_cnt_q == RX_LAST) begin
						rx_cnt_d = '0;
						ovf_d    = 1'b1;
					end else begin
						rx_cnt_d = rx_cnt_q + 1'b1;
					end
				end
				KIND_HOST_READ: begin
					if (rx_cnt_q == '0) begin
						info.status = STATUS_RX_EMPTY;
					end else begin
						ram_ctl.rx_rd    = 1'b1;
						info.use_rx_data = 1'b1;
						rx_rptr_d = (rx_rptr_q == RX_LAST) ? '0 : rx_rptr_q + 1'b1;
						rx_cnt_d  = rx_cnt_q - 1'b1;
					end
				end
				KIND_HOST_WRITE: begin
					if (tx_cnt_q == TX_FULL) begin
						info.status = STATUS_TX_FULL;
					end else if (tx_cnt_q != '0 || tx_busy_q) begin
						ram_ctl.tx_wr = 1'b1;
						tx_wptr_d = (tx_wptr_q == TX_LAST) ? '0 : tx_wptr_q + 1'b1;
						tx_cnt_d  = tx_cnt_q + 1'b1;
					end else begin
						tx_busy_d        = 1'b1;
						info.send_valid  = 1'b1;
						info.direct_byte = data_byte;
					end
				end
				KIND_TX_DONE: begin
					if (tx_cnt_q != '0) begin
						ram_ctl.tx_rd    = 1'b1;
						info.send_valid  = 1'b1;
						info.use_tx_data = 1'b1;
						tx_rptr_d = (tx_rptr_q == TX_LAST) ? '0 : tx_rptr_q + 1'b1;
						tx_cnt_d  = tx_cnt_q - 1'b1;
					end else begin
						tx_busy_d = 1'b1 & 1'b0;
					end
				end
				KIND_FLUSH: begin
					rx_wptr_d = '0;
					rx_rptr_d = '0;
					rx_cnt_d  = '0;
					tx_wptr_d = '0;
					tx_rptr_d = '0;
					tx_cnt_d  = '0;
					tx_busy_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
		info.overflow = ovf_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wptr_q <= '0;
			rx_rptr_q <= '0;
			rx_cnt_q  <= '0;
			tx_wptr_q <= '0;
			tx_rptr_q <= '0;
			tx_cnt_q  <= '0;
			tx_busy_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			rx_wptr_q <= rx_wptr_d;
			rx_rptr_q <= rx_rptr_d;
			rx_cnt_q  <= rx_cnt_d;
			tx_wptr_q <= tx_wptr_d;
			tx_rptr_q <= tx_rptr_d;
			tx_cnt_q  <= tx_cnt_d;
			tx_busy_q <= tx_busy_d;
			ovf_q     <= ovf_d;
		end
	end

endmodule

[hw/rtl/uart_rx_tx_ring_buffer_unit.sv]
`timescale 1ns / 1ps
// An event transfer reaches result valid through stage 1 (RAM read), then the output register.
// Throughput: one event per cycle; each event does at most one access to one ring RAM.
// Stalls only when the output register is full and not taken.
// Reset (arst_n, async, active low) clears pointers, counts, busy, overflow flag and valid flags;
// ring RAM contents are not cleared and no clearing pass runs.

module uart_rx_tx_ring_buffer_unit import urtb_pkg::*; #(
	parameter int RX_DEPTH = 16,
	parameter int TX_DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	urtb_evt_if.sink   evt,
	urtb_res_if.source res
);

	`include "assert_macros.svh"

	localparam int RAW = $clog2(RX_DEPTH);
	localparam int TAW = $clog2(TX_DEPTH);

	ram_ctl_t       ram_ctl;
	res_info_t      info;
	logic [RAW-1:0] rx_wr_addr, rx_rd_addr;
	logic [TAW-1:0] tx_wr_addr, tx_rd_addr;
	logic [7:0]     rx_rd_data, tx_rd_data;

	// stage 1: event decoded, RAM read in flight
	logic      valid_s1;
	res_info_t info_s1;

	// output register
	logic       out_valid_q;
	logic [1:0] status_q;
	logic [7:0] read_byte_q;
	logic       send_valid_q;
	logic [7:0] send_byte_q;
	logic       overflow_q;

	logic go;
	logic adv;

	// stage 1 moves when the output register is empty or being drained
	assign adv       = valid_s1 && (!out_valid_q || res.ready);
	assign evt.ready = !valid_s1 || adv;
	assign go        = evt.valid && evt.ready;

	urtb_ctrl #(
		.RX_DEPTH(RX_DEPTH),
		.TX_DEPTH(TX_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.kind       (evt.kind),
		.data_byte  (evt.data_byte),
		.ram_ctl    (ram_ctl),
		.rx_wr_addr (rx_wr_addr),
		.rx_rd_addr (rx_rd_addr),
		.tx_wr_addr (tx_wr_addr),
		.tx_rd_addr (tx_rd_addr),
		.info       (info)
	);

	// Read data holds while stage 1 is stalled, since a new read
	// is only issued on a transfer into stage 1.
	urtb_ram #(
		.WIDTH(8),
		.DEPTH(RX_DEPTH)
	) u_rx_ram (
		.clk     (clk),
		.wr_en   (ram_ctl.rx_wr),
		.wr_addr (rx_wr_addr),
		.wr_data (evt.data_byte),
		.rd_en   (ram_ctl.rx_rd),
		.rd_addr (rx_rd_addr),
		.rd_data (rx_rd_data)
	);

	urtb_ram #(
		.WIDTH(8),
		.DEPTH(TX_DEPTH)
	) u_tx_ram (
		.clk     (clk),
		.wr_en   (ram_ctl.tx_wr),
		.wr_addr (tx_wr_addr),
		.wr_data (evt.data_byte),
		.rd_en   (ram_ctl.tx_rd),
		.rd_addr (tx_rd_addr),
		.rd_data (tx_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			info_s1 <= info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// merge RAM read data into the result
	always_ff @(posedge clk) begin
		if (adv) begin
			status_q     <= info_s1.status;
			read_byte_q  <= info_s1.use_rx_data ? rx_rd_data : 8'h00;
			send_valid_q <= info_s1.send_valid;
			send_byte_q  <= info_s1.use_tx_data ? tx_rd_data : info_s1.direct_byte;
			overflow_q   <= info_s1.overflow;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = status_q;
	assign res.read_byte     = read_byte_q;
	assign res.send_valid    = send_valid_q;
	assign res.send_byte     = send_byte_q;
	assign res.overflow_seen = overflow_q;

	// overflow is sticky across results
	`URTB_ASSERT(a_ovf_sticky, out_valid_q && overflow_q |=> overflow_q, "overflow flag dropped")
	// a byte goes to the transmitter only on a successful step
	`URTB_ASSERT(a_send_ok, out_valid_q && send_valid_q |-> status_q == STATUS_OK, "send with error status")
	// RX and TX data never both feed one result
	`URTB_ASSERT(a_one_src, valid_s1 |-> !(info_s1.use_rx_data && info_s1.use_tx_data), "two read sources")
	// a stalled stage 1 must block new events
	`URTB_ASSERT_ALWAYS(a_stall_blocks, valid_s1 && !adv |-> !evt.ready, "transfer into stalled stage")

endmodule

[tb/uart_rx_tx_ring_buffer_unit_checker.sv]
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the rings and checks every result in order.
module uart_rx_tx_ring_buffer_unit_checker import urtb_pkg::*; #(
	parameter int RX_DEPTH = 16,
	parameter int TX_DEPTH = 16
) (
	input logic  clk,
	input logic  arst_n,
	urtb_evt_if  evt,
	urtb_res_if  res,
	output int   mismatches,
	output int   outstanding,
	output int   checked
);

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] read_byte;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       overflow_seen;
	} ring_answer_t;

	logic [7:0]  rx_ring [RX_DEPTH];
	logic [7:0]  tx_ring [TX_DEPTH];
	int unsigned rx_wr, rx_rd, rx_cnt;
	int unsigned tx_wr, tx_rd, tx_cnt;
	logic        tx_busy;
	logic        rx_overflow;

	ring_answer_t ring_answer_q [$];

	task automatic note_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	function automatic void clear_pointers();
		rx_wr = 0;
		rx_rd = 0;
		rx_cnt = 0;
		tx_wr = 0;
		tx_rd = 0;
		tx_cnt = 0;
		tx_busy = 1'b0;
	endfunction

	// one event in, one answer out; updates the shadow rings
	function automatic ring_answer_t step_rings(input logic [2:0] kind, input logic [7:0] data);
		ring_answer_t a;
		a = '0;
		case (kind)
			KIND_LINE_BYTE: begin
				rx_ring[rx_wr] = data;
				rx_wr = (rx_wr + 1) % RX_DEPTH;
				rx_cnt++;
				// count wraps on reaching depth, flag sticks
				if (rx_cnt >= RX_DEPTH) begin
					rx_cnt = 0;
					rx_overflow = 1'b1;
				end
			end
			KIND_HOST_READ: begin
				if (rx_cnt == 0) begin
					a.status = STATUS_RX_EMPTY;
				end else begin
					a.read_byte = rx_ring[rx_rd];
					rx_rd = (rx_rd + 1) % RX_DEPTH;
					rx_cnt--;
				end
			end
			KIND_HOST_WRITE: begin
				if (tx_cnt >= TX_DEPTH) begin
					a.status = STATUS_TX_FULL;
				end else if (tx_cnt != 0 || tx_busy) begin
					tx_ring[tx_wr] = data;
					tx_wr = (tx_wr + 1) % TX_DEPTH;
					tx_cnt++;
				end else begin
					tx_busy = 1'b1;
					a.send_valid = 1'b1;
					a.send_byte = data;
				end
			end
			KIND_TX_DONE: begin
				if (tx_cnt != 0) begin
					tx_cnt--;
					a.send_valid = 1'b1;
					a.send_byte = tx_ring[tx_rd];
					tx_rd = (tx_rd + 1) % TX_DEPTH;
				end else begin
					tx_busy = 1'b0;
				end
			end
			KIND_FLUSH: clear_pointers();
			default: ;
		endcase
		a.overflow_seen = rx_overflow;
		return a;
	endfunction

	initial begin
		mismatches = 0;
		outstanding = 0;
		checked = 0;
		rx_overflow = 1'b0;
		clear_pointers();
		for (int i = 0; i < RX_DEPTH; i++) rx_ring[i] = '0;
		for (int i = 0; i < TX_DEPTH; i++) tx_ring[i] = '0;
	end

	// sampled mid-cycle: a transfer seen here completes at the next rising edge
	always @(negedge clk) begin
		ring_answer_t got, want;
		if (!arst_n) begin
			clear_pointers();
			rx_overflow = 1'b0;
			ring_answer_q.delete();
		end else begin
			if (res.valid && res.ready) begin
				got = '{res.status, res.read_byte, res.send_valid, res.send_byte,
					res.overflow_seen};
				if (ring_answer_q.size() == 0) begin
					note_mismatch($sformatf("result with nothing pending: %p", got));
				end else begin
					want = ring_answer_q.pop_front();
					if (got.status !== want.status)
						note_mismatch($sformatf("#%0d status %0d, want %0d",
							checked, got.status, want.status));
					if (got.read_byte !== want.read_byte)
						note_mismatch($sformatf("#%0d read_byte %02h, want %02h",
							checked, got.read_byte, want.read_byte));
					if (got.send_valid !== want.send_valid)
						note_mismatch($sformatf("#%0d send_valid %0b, want %0b",
							checked, got.send_valid, want.send_valid));
					if (got.send_byte !== want.send_byte)
						note_mismatch($sformatf("#%0d send_byte %02h, want %02h",
							checked, got.send_byte, want.send_byte));
					if (got.overflow_seen !== want.overflow_seen)
						note_mismatch($sformatf("#%0d overflow_seen %0b, want %0b",
							checked, got.overflow_seen, want.overflow_seen));
				end
				checked++;
			end
			if (evt.valid && evt.ready)
				ring_answer_q.push_back(step_rings(evt.kind, evt.data_byte));
			outstanding = ring_answer_q.size();
		end
	end

endmodule

[tb/uart_rx_tx_ring_buffer_unit_test.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the UART ring buffer unit. All checking lives in the
// checker instance; this module only drives events, pulls results and ends the run.
module uart_rx_tx_ring_buffer_unit_test;
	import urtb_pkg::*;

	localparam int RX_DEPTH = 16;
	localparam int TX_DEPTH = 16;

	// kinds the block must leave alone
	localparam logic [2:0] KIND_SPARE_5 = 3'd5;
	localparam logic [2:0] KIND_SPARE_6 = 3'd6;
	localparam logic [2:0] KIND_SPARE_7 = 3'd7;

	localparam int PHASE_EVENTS = 475;     // counted events per idle/stall mix
	localparam int PRESSURE_EVENTS = 48;   // offered while the result side is held off
	localparam int HOLD_CYCLES = 300;      // length of the long result hold-off
	localparam int DRAIN_CYCLES = 10;      // margin after the last pending result comes back
	localparam int CYCLE_LIMIT = 200000;   // several times the slowest legal run

	logic clk;
	logic arst_n;

	urtb_evt_if evt_ch ();
	urtb_res_if res_ch ();

	int mismatches;
	int outstanding;
	int checked;

	int snd_idle_pct;   // chance per cycle that the event side sits idle
	int rcv_stall_pct;  // chance per cycle that the result side withholds ready
	logic rx_hold;      // long hold-off on the result side
	event hold_start;

	int counted_events; // events that do real work (kinds 0..4)
	int kind_seen [8];
	int cycle_count;

	uart_rx_tx_ring_buffer_unit #(
		.RX_DEPTH(RX_DEPTH),
		.TX_DEPTH(TX_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_ch),
		.res(res_ch)
	);

	uart_rx_tx_ring_buffer_unit_checker #(
		.RX_DEPTH(RX_DEPTH),
		.TX_DEPTH(TX_DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_ch),
		.res(res_ch),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: ends the run if the stimulus or the drain never finishes.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still pending", cycle_count, outstanding);
		$display("uart_rx_tx_ring_buffer_unit_test: done, errors");
		$finish;
	end

	// Result side: random stalls per cycle, forced low while the hold-off runs.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= !rx_hold && ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// Hold-off counted here so the event side keeps offering transfers meanwhile.
	initial begin
		rx_hold = 1'b0;
		forever begin
			@(hold_start);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	// One event transfer. Called at a rising edge; returns at the edge where the
	// transfer happened. Ready is sampled mid-cycle so the decision is race-free.
	task automatic send_evt(input logic [2:0] kind, input logic [7:0] data);
		bit taken;
		taken = 1'b0;
		while ($urandom_range(99) < snd_idle_pct) begin
			evt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.kind <= kind;
		evt_ch.data_byte <= data;
		while (!taken) begin
			@(negedge clk);
			taken = evt_ch.ready;
			@(posedge clk);
		end
		kind_seen[kind]++;
		if (kind <= KIND_FLUSH)
			counted_events++;
	endtask

	// Line bytes in, then host reads; long bursts push the receive count over depth.
	task automatic rx_burst();
		int n;
		int m;
		n = $urandom_range(18, 1);
		m = $urandom_range(n + 2, 0);
		repeat (n) send_evt(KIND_LINE_BYTE, 8'($urandom));
		repeat (m) send_evt(KIND_HOST_READ, 8'($urandom));
	endtask

	// Host writes with the odd transmit-complete mixed in, so the transmit ring
	// fills (and refuses) on long bursts; then completes to drain it.
	task automatic tx_burst();
		int n;
		int m;
		n = $urandom_range(20, 1);
		repeat (n) begin
			send_evt(KIND_HOST_WRITE, 8'($urandom));
			if ($urandom_range(3) == 0)
				send_evt(KIND_TX_DONE, 8'($urandom));
		end
		m = $urandom_range(n + 2, 0);
		repeat (m) send_evt(KIND_TX_DONE, 8'($urandom));
	endtask

	// Unordered events of any kind, including the unused codes.
	task automatic noise_run();
		repeat ($urandom_range(4, 1))
			send_evt(3'($urandom_range(7)), 8'($urandom));
	endtask

	initial begin
		int sel;
		int phase_end;
		arst_n = 1'b0;
		evt_ch.valid <= 1'b0;
		evt_ch.kind <= KIND_LINE_BYTE;
		evt_ch.data_byte <= 8'h00;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		counted_events = 0;
		foreach (kind_seen[i]) kind_seen[i] = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty read, complete while idle, direct send vs. queued send,
		// flush clearing the busy transmitter, extreme data bytes, unused kinds,
		// and a read after a flush.
		send_evt(KIND_HOST_READ, 8'h00);
		send_evt(KIND_TX_DONE, 8'hFF);
		send_evt(KIND_HOST_WRITE, 8'h00);
		send_evt(KIND_HOST_WRITE, 8'hFF);
		send_evt(KIND_HOST_WRITE, 8'h5A);
		send_evt(KIND_TX_DONE, 8'h00);
		send_evt(KIND_TX_DONE, 8'h00);
		send_evt(KIND_TX_DONE, 8'h00);
		send_evt(KIND_HOST_WRITE, 8'hA5);
		send_evt(KIND_FLUSH, 8'hFF);
		send_evt(KIND_HOST_WRITE, 8'h3C);
		send_evt(KIND_LINE_BYTE, 8'h00);
		send_evt(KIND_LINE_BYTE, 8'hFF);
		send_evt(KIND_LINE_BYTE, 8'h81);
		send_evt(KIND_HOST_READ, 8'hFF);
		send_evt(KIND_HOST_READ, 8'h00);
		send_evt(KIND_HOST_READ, 8'h00);
		send_evt(KIND_HOST_READ, 8'h00);
		send_evt(KIND_SPARE_5, 8'hFF);
		send_evt(KIND_SPARE_6, 8'h00);
		send_evt(KIND_SPARE_7, 8'hAA);
		send_evt(KIND_LINE_BYTE, 8'h7E);
		send_evt(KIND_FLUSH, 8'h00);
		send_evt(KIND_HOST_READ, 8'h00);
		send_evt(KIND_TX_DONE, 8'h00);

		// Backpressure: results held off for a long stretch while events keep
		// coming back to back, so the output register fills and input stalls.
		-> hold_start;
		repeat (PRESSURE_EVENTS)
			send_evt(3'($urandom_range(3)), 8'($urandom));

		// Random: four idle/stall mixes, mostly well-formed bursts, some noise.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 74; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 74; end
				default: begin snd_idle_pct = 26; rcv_stall_pct = 26; end
			endcase
			phase_end = counted_events + PHASE_EVENTS;
			while (counted_events < phase_end) begin
				sel = $urandom_range(99);
				if (sel < 35)
					rx_burst();
				else if (sel < 70)
					tx_burst();
				else if (sel < 92)
					noise_run();
				else
					send_evt(KIND_FLUSH, 8'($urandom));
			end
		end
		evt_ch.valid <= 1'b0;

		// Drain: every predicted result must come back, then nothing more may.
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d events: line %0d, read %0d, write %0d, tx-done %0d, flush %0d, spare %0d",
			counted_events + kind_seen[5] + kind_seen[6] + kind_seen[7],
			kind_seen[KIND_LINE_BYTE], kind_seen[KIND_HOST_READ], kind_seen[KIND_HOST_WRITE],
			kind_seen[KIND_TX_DONE], kind_seen[KIND_FLUSH],
			kind_seen[5] + kind_seen[6] + kind_seen[7]);
		$display("%0d results compared over four idle/stall mixes and one long output hold-off",
			checked);
		if (mismatches == 0) begin
			$display("uart_rx_tx_ring_buffer_unit_test: done, clean");
		end else begin
			$display("uart_rx_tx_ring_buffer_unit_test: done, errors");
		end
		$finish;
	end

endmodule
